// ===== src/perspective_point_projection_assert.svh =====
// Assertion macros for the perspective point projection block.
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("perspective_point_projection: check failed");
`define PPP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("perspective_point_projection: reset check failed");
`else
`define PPP_ASSERT(lbl, prop)
`define PPP_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/ppp_pkg.sv =====
// Shared constants for the perspective point projection block.
`timescale 1ns / 1ps
package ppp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DIM_W         = 14;
    localparam int QUOT_W        = 41;
    localparam int NUM_W         = 79;
    localparam int SUM_W         = 44;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_XY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_ZW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_ZW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_XY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_ZW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

    localparam logic [QUOT_W-1:0] OFFSET_CAP = 41'h100_0000_0000;
endpackage

// ===== src/ppp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module ppp_div #(
    parameter int DIV_W = 50,
    parameter int TAG_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [ppp_pkg::NUM_W-1:0] in_num,
    input  logic [DIV_W-1:0]          in_div,
    input  logic [TAG_W-1:0]          in_tag,
    output logic                      out_valid,
    output logic [ppp_pkg::QUOT_W-1:0] out_quot,
    output logic                      out_ovf,
    output logic [TAG_W-1:0]          out_tag
);
    localparam int QW = ppp_pkg::QUOT_W;
    localparam int EW = DIV_W + QW;

    logic [EW-1:0]    rem_reg  [0:QW];
    logic [DIV_W-1:0] div_reg  [0:QW];
    logic [QW-1:0]    quot_reg [0:QW];
    logic             ovf_reg  [0:QW];
    logic [TAG_W-1:0] tag_reg  [0:QW];
    logic             vld_reg  [0:QW];

    logic [EW-1:0] num_ext;
    logic [EW-1:0] div_top;
    assign num_ext = EW'(in_num);
    assign div_top = EW'(in_div) << QW;

    // Entry stage flags a quotient that would not fit in QW bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0]  <= num_ext;
            div_reg[0]  <= in_div;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= (num_ext >= div_top);
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [EW-1:0] shifted;
        logic          take;
        assign shifted = EW'(div_reg[k-1]) << (QW - k);
        assign take    = rem_reg[k-1] >= shifted;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                rem_reg[k]  <= take ? rem_reg[k-1] - shifted : rem_reg[k-1];
                div_reg[k]  <= div_reg[k-1];
                quot_reg[k] <= quot_reg[k-1] | (QW'(take) << (QW - k));
                ovf_reg[k]  <= ovf_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quot  = quot_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_tag   = tag_reg[QW];
endmodule

// ===== src/perspective_point_projection.sv =====
// Top level of the perspective point projection block.
`timescale 1ns / 1ps
`include "perspective_point_projection_assert.svh"
// Projects one signed fixed-point 3D point per transfer through rows 0, 1 and 3 of a view
// matrix and returns a visibility flag on m_tuser and saturated screen coordinates on m_tdata.
// The block accepts one point every clock cycle while the output register is empty or being
// taken. The pipeline is three arithmetic stages, a 42-stage divider and the output register,
// for any FRAC_BITS. The divider has an entry stage that flags quotient overflow and 41 stages
// that each retire one quotient bit. The whole pipeline advances together whenever the output
// register is empty or being taken, so s_tready follows m_tready while a result waits. The user
// must write matrix and viewport registers through the plain write port only while no point
// is in flight; the block itself does not enforce this.
module perspective_point_projection #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,  // pos_x, pos_y, pos_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // screen_x, screen_y
    output logic                          m_tuser   // visible
);
    localparam int CW     = ppp_pkg::COORD_W;
    localparam int DOT_W  = 66 - FRAC_BITS;
    localparam int HALF_W = ppp_pkg::DIM_W - 1 + FRAC_BITS;
    localparam int SW     = ppp_pkg::SUM_W;
    localparam int TAG_W  = 2 + HALF_W;
    localparam logic signed [DOT_W-1:0] VIS_MIN = DOT_W'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sh8000_0000);

    // Configuration registers.
    logic [ppp_pkg::CFG_W-1:0] row_reg [0:5];
    logic [ppp_pkg::DIM_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ppp_pkg::CFG_W'(64'd1 << FRAC_BITS);
            row_reg[1] <= '0;
            row_reg[2] <= ppp_pkg::CFG_W'(64'd1 << (32 + FRAC_BITS));
            row_reg[3] <= '0;
            row_reg[4] <= '0;
            row_reg[5] <= ppp_pkg::CFG_W'(64'd1 << FRAC_BITS);
            width_reg  <= ppp_pkg::WIDTH_RST;
            height_reg <= ppp_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ppp_pkg::REG_ROW0_XY: row_reg[0] <= cfg_data;
                ppp_pkg::REG_ROW0_ZW: row_reg[1] <= cfg_data;
                ppp_pkg::REG_ROW1_XY: row_reg[2] <= cfg_data;
                ppp_pkg::REG_ROW1_ZW: row_reg[3] <= cfg_data;
                ppp_pkg::REG_ROW3_XY: row_reg[4] <= cfg_data;
                ppp_pkg::REG_ROW3_ZW: row_reg[5] <= cfg_data;
                ppp_pkg::REG_WIDTH:   width_reg  <= cfg_data[ppp_pkg::DIM_W-1:0];
                ppp_pkg::REG_HEIGHT:  height_reg <= cfg_data[ppp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can take a result.
    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    logic signed [CW-1:0] px, py, pz;
    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];
    assign pz = s_tdata[95:64];

    // Stage 1: nine coefficient products, constants held for stage 2.
    logic                   s1_valid_reg;
    logic signed [63:0]     s1_prod_reg [0:8];
    logic signed [CW-1:0]   s1_const_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                s1_prod_reg[3*r]   <= $signed(row_reg[2*r][31:0]) * px;
                s1_prod_reg[3*r+1] <= $signed(row_reg[2*r][63:32]) * py;
                s1_prod_reg[3*r+2] <= $signed(row_reg[2*r+1][31:0]) * pz;
                s1_const_reg[r]    <= $signed(row_reg[2*r+1][63:32]);
            end
        end
    end

    // Stage 2: floor each product to the fraction width and sum the row.
    logic                    s2_valid_reg;
    logic signed [DOT_W-1:0] s2_dot_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                s2_dot_reg[r] <= DOT_W'(s1_prod_reg[3*r] >>> FRAC_BITS)
                               + DOT_W'(s1_prod_reg[3*r+1] >>> FRAC_BITS)
                               + DOT_W'(s1_prod_reg[3*r+2] >>> FRAC_BITS)
                               + DOT_W'(s1_const_reg[r]);
            end
        end
    end

    // Stage 3: depth test, magnitudes scaled by the viewport size.
    logic                         s3_valid_reg;
    logic                         s3_vis_reg;
    logic                         s3_negx_reg, s3_negy_reg;
    logic [ppp_pkg::NUM_W-1:0]    s3_numx_reg, s3_numy_reg;
    logic [DOT_W-2:0]             s3_w_reg;
    logic [HALF_W-1:0]            s3_hw_reg, s3_hh_reg;
    logic [DOT_W-1:0]             magx, magy;

    assign magx = s2_dot_reg[0][DOT_W-1] ? DOT_W'(-s2_dot_reg[0]) : DOT_W'(s2_dot_reg[0]);
    assign magy = s2_dot_reg[1][DOT_W-1] ? DOT_W'(-s2_dot_reg[1]) : DOT_W'(s2_dot_reg[1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (adv) begin
            s3_vis_reg  <= s2_dot_reg[2] > VIS_MIN;
            s3_negx_reg <= s2_dot_reg[0][DOT_W-1];
            s3_negy_reg <= s2_dot_reg[1][DOT_W-1];
            s3_numx_reg <= ppp_pkg::NUM_W'(magx * width_reg) << (FRAC_BITS - 1);
            s3_numy_reg <= ppp_pkg::NUM_W'(magy * height_reg) << (FRAC_BITS - 1);
            s3_w_reg    <= s2_dot_reg[2][DOT_W-2:0];
            s3_hw_reg   <= HALF_W'(width_reg) << (FRAC_BITS - 1);
            s3_hh_reg   <= HALF_W'(height_reg) << (FRAC_BITS - 1);
        end
    end

    // Divider lanes for x and y.
    logic                         dx_valid, dy_valid;
    logic [ppp_pkg::QUOT_W-1:0]   dx_quot, dy_quot;
    logic                         dx_ovf, dy_ovf;
    logic [TAG_W-1:0]             dx_tag, dy_tag;

    ppp_div #(.DIV_W(DOT_W - 1), .TAG_W(TAG_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(s3_valid_reg),
        .in_num(s3_numx_reg), .in_div(s3_w_reg),
        .in_tag({s3_vis_reg, s3_negx_reg, s3_hw_reg}),
        .out_valid(dx_valid), .out_quot(dx_quot), .out_ovf(dx_ovf), .out_tag(dx_tag)
    );

    ppp_div #(.DIV_W(DOT_W - 1), .TAG_W(TAG_W)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(s3_valid_reg),
        .in_num(s3_numy_reg), .in_div(s3_w_reg),
        .in_tag({s3_vis_reg, s3_negy_reg, s3_hh_reg}),
        .out_valid(dy_valid), .out_quot(dy_quot), .out_ovf(dy_ovf), .out_tag(dy_tag)
    );

    // Output stage: cap the offset, apply its sign around the center, saturate.
    logic [ppp_pkg::QUOT_W-1:0] offx, offy;
    logic signed [SW-1:0]       sumx, sumy, satx, saty;
    logic                       out_vis;

    assign offx = (dx_ovf || dx_quot > ppp_pkg::OFFSET_CAP) ? ppp_pkg::OFFSET_CAP : dx_quot;
    assign offy = (dy_ovf || dy_quot > ppp_pkg::OFFSET_CAP) ? ppp_pkg::OFFSET_CAP : dy_quot;
    // Screen y grows downward, so a positive row-1 product moves the point up.
    assign sumx = dx_tag[HALF_W] ? SW'(dx_tag[HALF_W-1:0]) - SW'(offx)
                                 : SW'(dx_tag[HALF_W-1:0]) + SW'(offx);
    assign sumy = dy_tag[HALF_W] ? SW'(dy_tag[HALF_W-1:0]) + SW'(offy)
                                 : SW'(dy_tag[HALF_W-1:0]) - SW'(offy);
    assign satx = (sumx > SAT_MAX) ? SAT_MAX : ((sumx < SAT_MIN) ? SAT_MIN : sumx);
    assign saty = (sumy > SAT_MAX) ? SAT_MAX : ((sumy < SAT_MIN) ? SAT_MIN : sumy);
    // Both lanes carry the same visibility flag.
    assign out_vis = dx_tag[HALF_W+1] && dy_tag[HALF_W+1];

    logic          m_vis_reg;
    logic [CW-1:0] m_x_reg, m_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dx_valid && dy_valid;
        end
        if (adv) begin
            m_vis_reg <= out_vis;
            m_x_reg   <= out_vis ? CW'(satx) : '0;
            m_y_reg   <= out_vis ? CW'(saty) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_vis_reg;

    // Both divider lanes step in lockstep with the same valid pattern.
    `PPP_ASSERT(a_lanes_aligned, dx_valid == dy_valid)
    // A hidden point always reports zero coordinates.
    `PPP_ASSERT(a_hidden_zero, m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    // A stalled result blocks new input transfers.
    `PPP_ASSERT(a_stall_blocks, m_tvalid && !m_tready |-> !s_tready)
    // Reset empties the output register.
    `PPP_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid)
endmodule
